>>> rtl/bffa_pkg.sv
package bffa_pkg;

   // Operation codes carried on the request tuser.
   localparam logic [2:0] OP_ALLOC = 3'd0;
   localparam logic [2:0] OP_FREE  = 3'd1;
   localparam logic [2:0] OP_COUNT = 3'd2;
   localparam logic [2:0] OP_LOAD  = 3'd3;
   localparam logic [2:0] OP_READ  = 3'd4;

   // Status codes carried on the response tuser.
   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_FULL  = 2'd1;
   localparam logic [1:0] ST_RANGE = 2'd2;

   // Summary of one bitmap byte, produced by the shared byte unit.
   typedef struct packed {
      logic [3:0] popcnt;
      logic       has_zero;
      logic [2:0] zero_bit;
      logic [7:0] set_byte;
   } byte_info_type;

endpackage

>>> rtl/bffa_ram.sv
module bffa_ram #(
   parameter int WIDTH  = 8,
   parameter int DEPTH  = 128,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/bffa_byte_unit.sv
module bffa_byte_unit
   import bffa_pkg::*;
(
   input  logic [7:0]    data_in,
   output byte_info_type info
);

   // Population count, and the first clear bit counted from the MSB.
   always_comb begin
      info.popcnt   = 4'd0;
      info.zero_bit = 3'd0;
      info.has_zero = ~(&data_in);
      for (int k = 7; k >= 0; k--) begin
         if (!data_in[7-k]) begin
            info.zero_bit = 3'(k);
         end
         info.popcnt = info.popcnt + {3'b000, data_in[k]};
      end
      info.set_byte = data_in | (8'h80 >> info.zero_bit);
   end

endmodule

>>> rtl/bitmap_first_free_allocator.sv
// First-fit allocator over a bitmap of MAP_BYTES bytes held in a single RAM.
// Position 1 is the most significant bit of byte 0.
//
// Requests arrive as stream transactions: req_tuser carries the operation
// (allocate, free, count, load byte, read byte) and req_tdata the position,
// byte index and byte value. Every request yields exactly one response
// transaction; rsp_tuser carries the status, rsp_tdata the results.
//
// Allocate and count walk the first span = min(map_bytes, MAP_BYTES) bytes
// through one shared byte unit, one byte per cycle, with the RAM read port
// streaming one address ahead; allocate stops at the first byte with a clear
// bit. One request is worked on at a time, and req_tready is low while
// it is.
//
// The finished response sits in an output register, so the next request is
// taken while a response waits for rsp_tready; a second result then holds
// until the register drains. After reset the block clears the bitmap, one
// byte per cycle, with req_tready low; the CSR port stays usable during that
// pass. map_bytes resets to 128.
module bitmap_first_free_allocator
   import bffa_pkg::*;
#(
   parameter int MAP_BYTES = 128
) (
   input  logic        clock,
   input  logic        reset,

   input  logic        req_tvalid,
   output logic        req_tready,
   // bit_position [10:0], byte_index [17:11], byte_value [25:18], zeros above.
   input  logic [31:0] req_tdata,
   // op [2:0].
   input  logic [2:0]  req_tuser,

   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // alloc_position [10:0], used_count [21:11], byte_out [29:22], zeros above.
   output logic [31:0] rsp_tdata,
   // status [1:0].
   output logic [1:0]  rsp_tuser,

   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   localparam int ADDR_W = (MAP_BYTES > 1) ? $clog2(MAP_BYTES) : 1;
   localparam logic [12:0] MAP_BYTES_W = 13'(MAP_BYTES);
   localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(MAP_BYTES - 1);

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_SCAN,
      S_FREE_RD,
      S_READ_RD,
      S_DONE
   } state_type;

   state_type         state_ff, state_in;
   logic [2:0]        op_ff, op_in;
   logic [7:0]        mask_ff, mask_in;
   logic [ADDR_W-1:0] rmw_addr_ff, rmw_addr_in;
   logic [7:0]        scan_idx_ff, scan_idx_in;
   logic              rd_pend_ff, rd_pend_in;
   logic [7:0]        rd_idx_ff, rd_idx_in;
   logic [10:0]       acc_ff, acc_in;
   logic [10:0]       res_pos_ff, res_pos_in;
   logic [10:0]       res_cnt_ff, res_cnt_in;
   logic [7:0]        res_byte_ff, res_byte_in;
   logic [1:0]        res_st_ff, res_st_in;
   logic [ADDR_W-1:0] clr_addr_ff, clr_addr_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [31:0]       rsp_data_ff, rsp_data_in;
   logic [1:0]        rsp_user_ff, rsp_user_in;
   logic [7:0]        map_bytes_ff, map_bytes_in;

   logic              ram_we;
   logic [ADDR_W-1:0] ram_waddr;
   logic [7:0]        ram_wdata;
   logic [ADDR_W-1:0] ram_raddr;
   logic [7:0]        ram_rdata;
   byte_info_type     info;

   // Request fields.
   logic [2:0]  in_op;
   logic [10:0] in_pos;
   logic [6:0]  in_idx;
   logic [7:0]  in_val;

   logic [7:0]  span;
   logic [10:0] span_bits;
   logic [10:0] pos_m1;
   logic        idx_ok;
   logic        scan_issue;
   logic        csr_wr;

   assign in_op  = req_tuser;
   assign in_pos = req_tdata[10:0];
   assign in_idx = req_tdata[17:11];
   assign in_val = req_tdata[25:18];

   // The searched span never exceeds the store, and never exceeds 255 bytes.
   assign span       = (13'(map_bytes_ff) > MAP_BYTES_W) ? 8'(MAP_BYTES_W) : map_bytes_ff;
   assign span_bits  = {span, 3'b000};
   assign pos_m1     = in_pos - 11'd1;
   assign idx_ok     = 13'(in_idx) < MAP_BYTES_W;
   assign scan_issue = scan_idx_ff < span;

   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_pready = 1'b1;
   assign csr_prdata = csr_paddr[2] ? 32'd0 : {24'd0, map_bytes_ff};

   bffa_ram #(
      .WIDTH (8),
      .DEPTH (MAP_BYTES)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   bffa_byte_unit u_byte_unit (
      .data_in (ram_rdata),
      .info    (info)
   );

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      mask_in      = mask_ff;
      rmw_addr_in  = rmw_addr_ff;
      scan_idx_in  = scan_idx_ff;
      rd_pend_in   = rd_pend_ff;
      rd_idx_in    = rd_idx_ff;
      acc_in       = acc_ff;
      res_pos_in   = res_pos_ff;
      res_cnt_in   = res_cnt_ff;
      res_byte_in  = res_byte_ff;
      res_st_in    = res_st_ff;
      clr_addr_in  = clr_addr_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;
      map_bytes_in = map_bytes_ff;
      ram_we       = 1'b0;
      ram_waddr    = '0;
      ram_wdata    = 8'd0;
      ram_raddr    = ADDR_W'(scan_idx_ff);

      // A taken response empties the output register unless refilled below.
      rsp_valid_in = rsp_valid_ff && !rsp_tready;

      if (csr_wr && !csr_paddr[2]) begin
         map_bytes_in = csr_pwdata[7:0];
      end

      unique case (state_ff)
         S_CLEAR: begin
            ram_we      = 1'b1;
            ram_waddr   = clr_addr_ff;
            clr_addr_in = clr_addr_ff + 1'b1;
            if (clr_addr_ff == LAST_ADDR) begin
               state_in = S_IDLE;
            end
         end

         S_IDLE: begin
            if (req_tvalid) begin
               op_in       = in_op;
               res_pos_in  = 11'd0;
               res_cnt_in  = 11'd0;
               res_byte_in = 8'd0;
               res_st_in   = ST_OK;
               state_in    = S_DONE;
               unique case (in_op)
                  OP_ALLOC, OP_COUNT: begin
                     scan_idx_in = 8'd0;
                     rd_pend_in  = 1'b0;
                     acc_in      = 11'd0;
                     state_in    = S_SCAN;
                  end
                  OP_FREE: begin
                     // Position zero is a no-op; past the span is a range error.
                     if (in_pos != 11'd0) begin
                        if (in_pos > span_bits) begin
                           res_st_in = ST_RANGE;
                        end else begin
                           ram_raddr   = ADDR_W'(pos_m1[10:3]);
                           rmw_addr_in = ADDR_W'(pos_m1[10:3]);
                           mask_in     = 8'h80 >> pos_m1[2:0];
                           state_in    = S_FREE_RD;
                        end
                     end
                  end
                  OP_LOAD: begin
                     if (idx_ok) begin
                        ram_we    = 1'b1;
                        ram_waddr = ADDR_W'(in_idx);
                        ram_wdata = in_val;
                     end else begin
                        res_st_in = ST_RANGE;
                     end
                  end
                  OP_READ: begin
                     if (idx_ok) begin
                        ram_raddr = ADDR_W'(in_idx);
                        state_in  = S_READ_RD;
                     end else begin
                        res_st_in = ST_RANGE;
                     end
                  end
                  default: begin
                     // Unknown operations answer with all fields zero.
                  end
               endcase
            end
         end

         S_SCAN: begin
            // The read port runs one byte ahead of the byte unit.
            rd_pend_in = scan_issue;
            rd_idx_in  = scan_idx_ff;
            if (scan_issue) begin
               scan_idx_in = scan_idx_ff + 8'd1;
            end
            priority if (rd_pend_ff) begin
               if (op_ff == OP_ALLOC) begin
                  if (info.has_zero) begin
                     ram_we     = 1'b1;
                     ram_waddr  = ADDR_W'(rd_idx_ff);
                     ram_wdata  = info.set_byte;
                     res_pos_in = {rd_idx_ff, info.zero_bit} + 11'd1;
                     rd_pend_in = 1'b0;
                     state_in   = S_DONE;
                  end
               end else begin
                  acc_in = acc_ff + 11'(info.popcnt);
               end
            end else if (!scan_issue) begin
               // Every byte of the span has been examined.
               if (op_ff == OP_ALLOC) begin
                  res_st_in = ST_FULL;
               end else begin
                  res_cnt_in = acc_ff;
               end
               state_in = S_DONE;
            end else begin
               // First cycle of the scan: only the read is in flight.
            end
         end

         S_FREE_RD: begin
            ram_we    = 1'b1;
            ram_waddr = rmw_addr_ff;
            ram_wdata = ram_rdata & ~mask_ff;
            state_in  = S_DONE;
         end

         S_READ_RD: begin
            res_byte_in = ram_rdata;
            state_in    = S_DONE;
         end

         S_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {2'b00, res_byte_ff, res_cnt_ff, res_pos_ff};
               rsp_user_in  = res_st_ff;
               state_in     = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_addr_ff  <= '0;
         rd_pend_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
         map_bytes_ff <= 8'd128;
      end else begin
         state_ff     <= state_in;
         clr_addr_ff  <= clr_addr_in;
         rd_pend_ff   <= rd_pend_in;
         rsp_valid_ff <= rsp_valid_in;
         map_bytes_ff <= map_bytes_in;
      end
      op_ff       <= op_in;
      mask_ff     <= mask_in;
      rmw_addr_ff <= rmw_addr_in;
      scan_idx_ff <= scan_idx_in;
      rd_idx_ff   <= rd_idx_in;
      acc_ff      <= acc_in;
      res_pos_ff  <= res_pos_in;
      res_cnt_ff  <= res_cnt_in;
      res_byte_ff <= res_byte_in;
      res_st_ff   <= res_st_in;
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule

>>> rtl/bffa_checker.sv
module bffa_checker
   import bffa_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [31:0] rsp_tdata,
   input logic [1:0]  rsp_tuser
);

   // No response can appear in the cycle after reset.
   assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("response valid right after reset");

   // A stalled response holds its transaction.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled response changed");

   // Requests are worked on one at a time.
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request taken while busy");

   // Status is always a defined code.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tuser == ST_OK) || (rsp_tuser == ST_FULL) || (rsp_tuser == ST_RANGE))
      else $error("undefined status");

   // A granted position always comes with an ok status.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tdata[10:0] != 11'd0) |-> rsp_tuser == ST_OK)
      else $error("position returned with error status");

endmodule

bind bitmap_first_free_allocator bffa_checker u_bffa_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
